@@ rtl/bxq_pkg.sv @@
package bxq_pkg;

    localparam int KEY_W     = 64;
    localparam int KB_W      = 7;
    localparam int OP_W      = 2;
    localparam int STATUS_W  = 2;
    localparam int OUT_DATA_W = 72;  // xor_value + status, padded to whole bytes
    localparam int MAX_DEPTH = 64;
    localparam int POS_W     = 6;    // bit position inside the key, 0..63
    localparam logic [KB_W-1:0] KEY_BITS_RESET = 7'd63;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_MIN    = 2'd1,
        OP_MAX    = 2'd2,
        OP_CLEAR  = 2'd3
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

endpackage

@@ rtl/binary_trie_xor_query.sv @@
// Binary trie over the low key_bits bits of 64-bit keys, answering insert,
// minimum-xor query, maximum-xor query and clear, one result per item. Nodes
// live in a single synchronous memory (one {right, left} child pair per node);
// the root's pair sits in flip-flops, so reset and clear take effect at once
// and there is no clearing pass. An item is taken only while the block is idle
// and walks d trie levels, then stages its result, where d is the
// effective depth (key_bits, with 0 read as 1 and values above 64 as 64): the
// walk advances one trie level per cycle, paced by the node memory read.
// An insert that allocates a node at the bottom level also zeroes that leaf
// before it ends. Clear, a rejected insert (fewer than d free nodes) and a query
// on an empty trie finish right after acceptance. The next item can be taken
// while the previous result still waits in the output register.
module binary_trie_xor_query #(
    parameter int POOL_NODES = 4096
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration: key_bits
    input  logic                               i_cfg_wr_en,
    input  logic [bxq_pkg::KB_W-1:0]           i_cfg_wr_data,
    // input stream
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [bxq_pkg::KEY_W-1:0]          i_s_tdata,  // [63:0] key
    input  logic [bxq_pkg::OP_W-1:0]           i_s_tuser,  // [1:0] opcode
    // result stream
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [bxq_pkg::OUT_DATA_W-1:0]     o_m_tdata   // [63:0] xor_value,
                                                           // [65:64] status,
                                                           // [71:66] zero
);
    import bxq_pkg::*;

    localparam int IDX_W = $clog2(POOL_NODES);
    localparam int CNT_W = IDX_W + 1;
    localparam int SUM_W = ((CNT_W > KB_W) ? CNT_W : KB_W) + 1;
    localparam logic [SUM_W-1:0] POOL_SUM = SUM_W'(POOL_NODES);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_ZERO,
        S_DONE
    } t_state;

    t_state              r_state;
    t_opcode             r_op;
    logic [KEY_W-1:0]    r_key;
    logic [KEY_W-1:0]    r_acc;
    logic [POS_W-1:0]    r_pos;
    logic [IDX_W-1:0]    r_node;
    logic                r_fresh;     // current node was just allocated: children are zero
    logic [IDX_W-1:0]    r_root_l;
    logic [IDX_W-1:0]    r_root_r;
    logic [CNT_W-1:0]    r_used;
    logic [KB_W-1:0]     r_key_bits;
    t_status             r_status;
    logic                r_m_valid;
    logic [OUT_DATA_W-1:0] r_m_data;

    // node memory
    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    logic [2*IDX_W-1:0]   ram_wdata;
    logic [IDX_W-1:0]     ram_raddr;
    logic [2*IDX_W-1:0]   ram_rdata;

    // walk datapath
    logic [KB_W-1:0]      depth;
    logic                 s_xfer;
    logic                 room_short;
    logic                 root_empty;
    logic [IDX_W-1:0]     cur_l;
    logic [IDX_W-1:0]     cur_r;
    logic                 key_bit;
    logic                 want_max;
    logic                 pref_bit;
    logic [IDX_W-1:0]     ins_child;
    logic                 ins_alloc;
    logic [IDX_W-1:0]     alloc_idx;
    logic [IDX_W-1:0]     new_l;
    logic [IDX_W-1:0]     new_r;
    logic [IDX_W-1:0]     pref;
    logic [IDX_W-1:0]     other;
    logic                 take_pref;
    logic                 is_insert;
    logic [IDX_W-1:0]     n_node;
    logic                 out_free;

    bxq_ram #(
        .DATA_W (2 * IDX_W),
        .DEPTH  (POOL_NODES)
    ) u_nodes (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (ram_waddr),
        .i_wr_data (ram_wdata),
        .i_rd_addr (ram_raddr),
        .o_rd_data (ram_rdata)
    );

    // Effective depth: zero acts as one level, anything above 64 as 64.
    always_comb begin
        if (r_key_bits == '0) begin
            depth = KB_W'(1);
        end else if (r_key_bits > KB_W'(MAX_DEPTH)) begin
            depth = KB_W'(MAX_DEPTH);
        end else begin
            depth = r_key_bits;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign s_xfer     = i_s_tvalid && o_s_tready;

    // Reject an insert when fewer than depth free nodes remain.
    assign room_short = (SUM_W'(r_used) + SUM_W'(depth)) > POOL_SUM;
    assign root_empty = (r_root_l == '0) && (r_root_r == '0);

    // Children of the node at the current level: root from flops, a freshly
    // allocated node is known zero, anything else comes from memory.
    always_comb begin
        if (r_node == '0) begin
            cur_l = r_root_l;
            cur_r = r_root_r;
        end else if (r_fresh) begin
            cur_l = '0;
            cur_r = '0;
        end else begin
            cur_l = ram_rdata[IDX_W-1:0];
            cur_r = ram_rdata[2*IDX_W-1:IDX_W];
        end
    end

    assign key_bit   = r_key[r_pos];
    assign want_max  = (r_op == OP_MAX);
    assign pref_bit  = key_bit ^ want_max;
    assign is_insert = (r_op == OP_INSERT);

    assign ins_child = key_bit ? cur_r : cur_l;
    assign ins_alloc = r_fresh || (ins_child == '0);
    assign alloc_idx = r_used[IDX_W-1:0];
    assign new_l     = (!key_bit && ins_alloc) ? alloc_idx : cur_l;
    assign new_r     = ( key_bit && ins_alloc) ? alloc_idx : cur_r;

    assign pref      = pref_bit ? cur_r : cur_l;
    assign other     = pref_bit ? cur_l : cur_r;
    assign take_pref = (pref != '0);

    always_comb begin
        if (is_insert) begin
            n_node = ins_alloc ? alloc_idx : ins_child;
        end else begin
            n_node = take_pref ? pref : other;  // a missing pair leads back to the root
        end
    end

    // Read the next level's node in the same cycle the current one is decided.
    assign ram_raddr = n_node;

    // Write back a non-root parent when insert links a new child; zero a new leaf.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_node;
        ram_wdata = {new_r, new_l};
        case (r_state)
            S_WALK: begin
                ram_we = is_insert && ins_alloc && (r_node != '0);
            end
            S_ZERO: begin
                ram_we    = 1'b1;
                ram_wdata = '0;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    assign out_free = !r_m_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_root_l   <= '0;
            r_root_r   <= '0;
            r_used     <= CNT_W'(1);
            r_key_bits <= KEY_BITS_RESET;
            r_m_valid  <= 1'b0;
            r_fresh    <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_key_bits <= i_cfg_wr_data;
            end
            // drop the result once the sink takes it, unless a new one lands
            if (i_m_tready && (r_state != S_DONE)) begin
                r_m_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (s_xfer) begin
                        r_op     <= t_opcode'(i_s_tuser);
                        r_key    <= i_s_tdata;
                        r_acc    <= '0;
                        r_pos    <= POS_W'(depth - KB_W'(1));
                        r_node   <= '0;
                        r_fresh  <= 1'b0;
                        case (t_opcode'(i_s_tuser))
                            OP_CLEAR: begin
                                r_root_l <= '0;
                                r_root_r <= '0;
                                r_used   <= CNT_W'(1);
                                r_status <= ST_OK;
                                r_state  <= S_DONE;
                            end
                            OP_INSERT: begin
                                if (room_short) begin
                                    r_status <= ST_FULL;
                                    r_state  <= S_DONE;
                                end else begin
                                    r_status <= ST_OK;
                                    r_state  <= S_WALK;
                                end
                            end
                            OP_MIN, OP_MAX: begin
                                if (root_empty) begin
                                    r_status <= ST_EMPTY;
                                    r_state  <= S_DONE;
                                end else begin
                                    r_status <= ST_OK;
                                    r_state  <= S_WALK;
                                end
                            end
                            default: begin
                                r_status <= ST_OK;
                                r_state  <= S_DONE;
                            end
                        endcase
                    end
                end

                S_WALK: begin
                    if (is_insert) begin
                        if (ins_alloc) begin
                            r_used <= r_used + CNT_W'(1);
                            if (r_node == '0) begin
                                r_root_l <= new_l;
                                r_root_r <= new_r;
                            end
                        end
                        r_fresh <= ins_alloc;
                    end else begin
                        r_acc[r_pos] <= (take_pref == want_max);
                    end
                    r_node <= n_node;
                    r_pos  <= r_pos - POS_W'(1);
                    if (r_pos == '0) begin
                        // a leaf allocated at the bottom still needs its pair zeroed
                        r_state <= (is_insert && ins_alloc) ? S_ZERO : S_DONE;
                    end
                end

                S_ZERO: begin
                    r_state <= S_DONE;
                end

                S_DONE: begin
                    // hold the result until the output register frees up
                    if (out_free) begin
                        r_m_valid <= 1'b1;
                        r_m_data  <= {(OUT_DATA_W - KEY_W - STATUS_W)'(0), r_status, r_acc};
                        r_state   <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;

endmodule

@@ rtl/bxq_ram.sv @@
module bxq_ram #(
    parameter int DATA_W = 24,
    parameter int DEPTH  = 4096
) (
    input  logic                      i_clk,
    input  logic                      i_wr_en,
    input  logic [$clog2(DEPTH)-1:0]  i_wr_addr,
    input  logic [DATA_W-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0]  i_rd_addr,
    output logic [DATA_W-1:0]         o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule
